// ----- design/assert_macros.svh -----
// Assertion macros for the timer table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied
`define TTU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define TTU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/ttu_pkg.sv -----
// Package: types, codes and constants of the timer table unit
package ttu_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 16;
	localparam logic [15:0] TICK_STEP_RST = 16'd20;

	// request codes
	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_START  = 3'd2;
	localparam logic [2:0] REQ_STOP   = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BADSLOT = 2'd2;

	localparam logic [24:0] ELAPSED_MAX = 25'h1FFFFFF;

	// one slot entry in the slot memory
	typedef struct packed {
		logic [31:0] stamp;
		logic [24:0] elapsed;
		logic [23:0] period;
		logic [23:0] delay;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic       fired;
		logic       last;
	} res_t;

endpackage

// ----- design/ttu_mem.sv -----
// Slot memory: one write port, one read port, registered read data
module ttu_mem #(
	parameter int unsigned DEPTH = ttu_pkg::NUM_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  ttu_pkg::entry_t          wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output ttu_pkg::entry_t          rdata
);
	import ttu_pkg::*;

	entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/ttu_ctrl.sv -----
// Request sequencer: slot flags, update sweep and earliest-first firing scans
`include "assert_macros.svh"
module ttu_ctrl #(
	parameter int unsigned NUM_SLOTS = ttu_pkg::NUM_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   in_req,
	input  logic [3:0]                   in_sid,
	input  logic [23:0]                  in_fdel,
	input  logic [23:0]                  in_rper,
	input  logic [15:0]                  step,
	input  logic                         out_free,
	output logic                         res_push,
	output ttu_pkg::res_t                res,
	output logic                         mem_we,
	output logic [$clog2(NUM_SLOTS)-1:0] mem_waddr,
	output ttu_pkg::entry_t              mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(NUM_SLOTS)-1:0] mem_raddr,
	input  ttu_pkg::entry_t              mem_rdata
);
	import ttu_pkg::*;

	localparam int unsigned IW = $clog2(NUM_SLOTS);
	localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
	localparam logic [CW-1:0] RD_END = CW'(NUM_SLOTS);
	localparam logic [CW-1:0] RD_FIRST = CW'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_UPD  = 6'b000100,
		S_SCAN = 6'b001000,
		S_FIRE = 6'b010000,
		S_NONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [NUM_SLOTS-1:0] used_q, armed_q, ready_q;
	logic [2:0]  req_q;
	logic [3:0]  sid_q;
	logic [23:0] fdel_q, rper_q;
	logic [31:0] time_q;
	logic [CW-1:0] cnt_q, rd_q;
	logic        vld_s1;
	logic [IW-1:0] idx_s1;
	logic        found_q;
	logic [IW-1:0] best_q;
	logic [23:0] bdel_q, bper_q;
	logic [31:0] bstamp_q;

	logic          issuing, sweep_done;
	logic [IW-1:0] sid_idx, free_idx;
	logic          sid_ok, free_found;
	logic [25:0]   e_sum;
	logic [24:0]   e_sat;
	logic          e_rdy, upd_hit, scan_better;

	assign in_ready = (state_q == S_IDLE);
	assign sid_idx  = IW'(sid_q);
	assign sid_ok   = (sid_q != 4'd0) && (32'(sid_q) < NUM_SLOTS);
	assign issuing  = ((state_q == S_UPD) || (state_q == S_SCAN)) && (rd_q < RD_END);
	assign sweep_done = !issuing && !vld_s1;
	assign mem_re   = issuing;
	assign mem_raddr = rd_q[IW-1:0];

	// lowest free slot from 1 upward
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// elapsed update with saturation, due check
	assign e_sum = {1'b0, mem_rdata.elapsed} + 26'(step);
	assign e_sat = e_sum[25] ? ELAPSED_MAX : e_sum[24:0];
	assign e_rdy = (e_sat >= {1'b0, mem_rdata.delay});
	assign upd_hit = (state_q == S_UPD) && vld_s1 && armed_q[idx_s1];
	assign scan_better = (state_q == S_SCAN) && vld_s1 && ready_q[idx_s1] &&
		(!found_q || (mem_rdata.stamp < bstamp_q));

	// memory write mux
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		priority if (upd_hit) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1;
			mem_wdata = '{stamp: mem_rdata.stamp, elapsed: e_sat, period: mem_rdata.period,
				delay: e_rdy ? mem_rdata.period : mem_rdata.delay};
		end else if (state_q == S_EXEC && out_free && req_q == REQ_START && sid_ok) begin
			mem_we    = 1'b1;
			mem_waddr = sid_idx;
			mem_wdata = '{stamp: time_q, elapsed: '0, period: rper_q, delay: fdel_q};
		end else if (state_q == S_FIRE && out_free) begin
			mem_we    = 1'b1;
			mem_waddr = best_q;
			mem_wdata = '{stamp: time_q, elapsed: '0, period: bper_q, delay: bdel_q};
		end else begin
			mem_we = 1'b0;
		end
	end

	// result of the current state
	always_comb begin
		res_push = 1'b0;
		res      = '{status: ST_OK, slot: 4'd0, fired: 1'b0, last: 1'b1};
		unique case (state_q)
			S_EXEC: begin
				res_push = out_free;
				if (req_q == REQ_CREATE) begin
					res.status = free_found ? ST_OK : ST_FULL;
					res.slot   = free_found ? 4'(free_idx) : 4'd0;
				end else if (req_q == REQ_REMOVE || req_q == REQ_START || req_q == REQ_STOP) begin
					res.status = sid_ok ? ST_OK : ST_BADSLOT;
				end else begin
					res.status = ST_OK;
				end
			end
			S_FIRE: begin
				res_push  = out_free;
				res.slot  = 4'(best_q);
				res.fired = 1'b1;
				res.last  = (cnt_q == CW'(1));
			end
			S_NONE: res_push = out_free;
			S_IDLE, S_UPD, S_SCAN: res_push = 1'b0;
			default: res_push = 1'b0;
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			armed_q <= '0;
			ready_q <= '0;
			time_q  <= '0;
			cnt_q   <= '0;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issuing;
			if (issuing) begin
				rd_q <= rd_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_req == REQ_TICK) begin
							time_q  <= time_q + 32'(step);
							cnt_q   <= '0;
							rd_q    <= RD_FIRST;
							state_q <= S_UPD;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (req_q == REQ_CREATE && free_found) begin
							used_q[free_idx]  <= 1'b1;
							armed_q[free_idx] <= 1'b0;
							ready_q[free_idx] <= 1'b0;
						end else if (sid_ok && req_q == REQ_REMOVE) begin
							used_q[sid_idx]  <= 1'b0;
							armed_q[sid_idx] <= 1'b0;
							ready_q[sid_idx] <= 1'b0;
						end else if (sid_ok && req_q == REQ_START) begin
							armed_q[sid_idx] <= 1'b1;
							ready_q[sid_idx] <= 1'b0;
						end else if (sid_ok && req_q == REQ_STOP) begin
							armed_q[sid_idx] <= 1'b0;
							ready_q[sid_idx] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_UPD: begin
					// mark due slots, count them
					if (upd_hit && e_rdy) begin
						ready_q[idx_s1] <= 1'b1;
						cnt_q <= cnt_q + CW'(1);
					end
					if (sweep_done) begin
						rd_q    <= RD_FIRST;
						found_q <= 1'b0;
						state_q <= (cnt_q == '0) ? S_NONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_better) begin
						found_q <= 1'b1;
					end
					if (sweep_done) begin
						state_q <= S_FIRE;
					end
				end
				S_FIRE: begin
					if (out_free) begin
						ready_q[best_q] <= 1'b0;
						cnt_q   <= cnt_q - CW'(1);
						rd_q    <= RD_FIRST;
						found_q <= 1'b0;
						state_q <= (cnt_q == CW'(1)) ? S_IDLE : S_SCAN;
					end
				end
				S_NONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= in_req;
			sid_q  <= in_sid;
			fdel_q <= in_fdel;
			rper_q <= in_rper;
		end
		idx_s1 <= rd_q[IW-1:0];
		if (scan_better) begin
			best_q   <= idx_s1;
			bdel_q   <= mem_rdata.delay;
			bper_q   <= mem_rdata.period;
			bstamp_q <= mem_rdata.stamp;
		end
	end

	`TTU_ASSERT(a_fire_only_in_fire, (res_push && res.fired) |-> (state_q == S_FIRE), "fire outside fire state")
	`TTU_ASSERT(a_fire_has_ready, (state_q == S_FIRE) |-> (found_q && ready_q[best_q]), "firing slot not ready")
	`TTU_ASSERT(a_cnt_bound, (cnt_q < RD_END), "due count out of range")
	`TTU_ASSERT(a_s1_in_sweep, vld_s1 |-> ((state_q == S_UPD) || (state_q == S_SCAN)), "read data outside a sweep")

endmodule

// ----- design/multi_slot_software_timer_table_unit.sv -----
// Top level of the multi-slot software timer table unit
//
//   channel  dir  payload                                          handshake
//   s_axis   in   tuser: req_type; tdata: slot_id, first_delay,    s_tvalid/s_tready
//                 reload_period
//   m_axis   out  tuser: fired; tdata: status, result_slot; tlast  m_tvalid/m_tready
//   cfg      in   cfg_data: tick_step                              cfg_valid/cfg_ready
//
// Create, remove, start, stop and unknown requests are accepted, then executed once the
// output can take the result. A tick is accepted, then an update sweep runs over the slot
// memory, then for each expiring slot a scan and a fire step follow (one read port).
// A tick with no expiry ends with one result that reports no firing.
// Reset clears flags and time and sets tick_step to 20; the slot memory needs no clearing.
// A stalled output holds the sequencer; one beat waits in the output register.
module multi_slot_software_timer_table_unit #(
	parameter int unsigned NUM_SLOTS = ttu_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // slot_id[3:0], first_delay[27:4], reload_period[51:28], zero
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // status[1:0], result_slot[5:2], zero
	output logic [0:0]  m_tuser,   // fired[0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // tick_step
);
	import ttu_pkg::*;

	localparam int unsigned IW = $clog2(NUM_SLOTS);

	logic [15:0]   step_q;
	logic          out_free, res_push;
	res_t          res, out_q;
	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;

	// tick_step register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= TICK_STEP_RST;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	// output register
	assign out_free = !m_tvalid || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= res_push;
		end
	end
	always_ff @(posedge clk) begin
		if (out_free && res_push) begin
			out_q <= res;
		end
	end
	assign m_tdata = {2'b00, out_q.slot, out_q.status};
	assign m_tuser = out_q.fired;
	assign m_tlast = out_q.last;

	ttu_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_sid    (s_tdata[3:0]),
		.in_fdel   (s_tdata[27:4]),
		.in_rper   (s_tdata[51:28]),
		.step      (step_q),
		.out_free  (out_free),
		.res_push  (res_push),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ttu_mem #(.DEPTH(NUM_SLOTS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
